// File: rtl/core/assert_macros.svh
// assertion macros for the checker file of the lzss decoder
// no dependencies; included by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check, switched off while reset is asserted
`define LZSS_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// concurrent check that also holds during reset
`define LZSS_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/lzss_pkg.sv
// package of the lzss stream decoder: constants, state encodings, command and status structs
// no dependencies; imported by the controller, the datapath and the top level
package lzss_pkg;

	localparam int unsigned WIN_SIZE  = 4096;
	localparam int unsigned WIN_AW    = $clog2(WIN_SIZE);
	localparam int unsigned MAX_MATCH = 18;
	localparam int unsigned MIN_MATCH = MAX_MATCH - 15;
	localparam int unsigned LEN_W     = $clog2(MAX_MATCH + 1);

	localparam logic [31:0]       LZSS_MAGIC = 32'h4C5A_5353;
	localparam logic [WIN_AW-1:0] WP_INIT    = WIN_AW'(WIN_SIZE - MAX_MATCH);
	localparam logic [3:0]        HDR_MAGIC_END = 4'd3;
	localparam logic [3:0]        HDR_LEN_END   = 4'd7;
	localparam logic [3:0]        HDR_LAST      = 4'd15;
	localparam logic [3:0]        FLAG_UNITS    = 4'd8;

	// sequencer states
	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_DECODE = 6'b000010,
		ST_LIT    = 6'b000100,
		ST_ERR    = 6'b001000,
		ST_RD     = 6'b010000,
		ST_WR     = 6'b100000
	} ctl_state_t;

	// stream phase
	typedef enum logic [4:0] {
		PH_HEADER   = 5'b00001,
		PH_BODY     = 5'b00010,
		PH_MATCH_HI = 5'b00100,
		PH_DONE     = 5'b01000,
		PH_BAD      = 5'b10000
	} phase_t;

	typedef struct packed {
		logic load_in;
		logic hdr_step;
		logic flag_load;
		logic low_load;
		logic copy_start;
		logic rd_issue;
		logic emit_lit;
		logic emit_copy;
		logic emit_err;
		logic unit_done;
	} dp_cmd_t;

	typedef struct packed {
		logic hdr_last;
		logic magic_bad;
		logic len_zero;
		logic flag_empty;
		logic flag_lit;
		logic copy_last;
		logic byte_done;
		logic out_free;
	} dp_sts_t;

endpackage

// File: rtl/core/lzss_ctrl.sv
// controller of the lzss stream decoder: sequencer and stream phase
// depends on lzss_pkg; drives the datapath by dp_cmd_t, reads dp_sts_t
module lzss_ctrl
	import lzss_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	ctl_state_t state_q, state_d;
	phase_t     phase_q, phase_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		phase_d = phase_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = ST_DECODE;
				end
			end
			ST_DECODE: begin
				state_d = ST_IDLE;
				case (phase_q)
					PH_HEADER: begin
						cmd.hdr_step = 1'b1;
						if (sts.magic_bad) begin
							phase_d = PH_BAD;
							state_d = ST_ERR;
						end else if (sts.hdr_last) begin
							phase_d = sts.len_zero ? PH_DONE : PH_BODY;
						end
					end
					PH_BODY: begin
						if (sts.flag_empty) begin
							cmd.flag_load = 1'b1;
						end else if (sts.flag_lit) begin
							state_d = ST_LIT;
						end else begin
							cmd.low_load = 1'b1;
							phase_d      = PH_MATCH_HI;
						end
					end
					PH_MATCH_HI: begin
						cmd.copy_start = 1'b1;
						phase_d        = PH_BODY;
						state_d        = ST_RD;
					end
					default: begin
						// finished or abandoned stream: byte dropped
					end
				endcase
			end
			ST_LIT: begin
				if (sts.out_free) begin
					cmd.emit_lit  = 1'b1;
					cmd.unit_done = 1'b1;
					if (sts.byte_done)
						phase_d = PH_DONE;
					state_d = ST_IDLE;
				end
			end
			ST_ERR: begin
				if (sts.out_free) begin
					cmd.emit_err = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			ST_RD: begin
				cmd.rd_issue = 1'b1;
				state_d      = ST_WR;
			end
			ST_WR: begin
				if (sts.out_free) begin
					cmd.emit_copy = 1'b1;
					if (sts.byte_done) begin
						cmd.unit_done = 1'b1;
						phase_d       = PH_DONE;
						state_d       = ST_IDLE;
					end else if (sts.copy_last) begin
						cmd.unit_done = 1'b1;
						state_d       = ST_IDLE;
					end else begin
						state_d = ST_RD;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= PH_HEADER;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
		end
	end

endmodule

// File: rtl/core/lzss_dp.sv
// datapath of the lzss stream decoder: header, flag and match registers, history ring,
// output register; depends on lzss_pkg, commanded by lzss_ctrl
module lzss_dp
	import lzss_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] in_byte,
	input  dp_cmd_t    cmd,
	output dp_sts_t    sts,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       run_last,
	output logic       stream_done,
	output logic       bad_magic
);

	logic [7:0]        byte_q;
	logic [3:0]        hdr_cnt_q;
	logic [31:0]       magic_q;
	logic [31:0]       total_q;
	logic [31:0]       prod_q;
	logic [7:0]        flag_q;
	logic [3:0]        flag_left_q;
	logic [7:0]        low_q;
	logic [WIN_AW-1:0] wp_q;
	logic [WIN_AW-1:0] src_q;
	logic [LEN_W-1:0]  len_q;

	logic [7:0]        ring [WIN_SIZE];
	logic [7:0]        rd_data_q;
	logic              rd_ok_q;

	logic              out_valid_q;
	logic [7:0]        out_byte_q;
	logic              out_last_q;
	logic              out_done_q;
	logic              out_bad_q;

	logic [31:0]       magic_next;
	logic [31:0]       prod_inc;
	logic [WIN_AW-1:0] src_rel;
	logic              src_filled;
	logic [7:0]        copy_byte;
	logic              ring_we;
	logic [7:0]        ring_wdata;

	assign magic_next = {magic_q[23:0], byte_q};
	assign prod_inc   = prod_q + 32'd1;

	// ring entries written so far run from the start position up, one per output byte
	assign src_rel    = src_q - WP_INIT;
	assign src_filled = (prod_q[31:WIN_AW] != '0) ||
		({{(32-WIN_AW){1'b0}}, src_rel} < prod_q);

	assign copy_byte  = rd_ok_q ? rd_data_q : 8'h00;
	assign ring_we    = cmd.emit_lit | cmd.emit_copy;
	assign ring_wdata = cmd.emit_lit ? byte_q : copy_byte;

	always_comb begin
		sts.hdr_last   = (hdr_cnt_q == HDR_LAST);
		sts.magic_bad  = (hdr_cnt_q == HDR_MAGIC_END) && (magic_next != LZSS_MAGIC);
		sts.len_zero   = (total_q == '0);
		sts.flag_empty = (flag_left_q == '0);
		sts.flag_lit   = flag_q[0];
		sts.copy_last  = (len_q == LEN_W'(1));
		sts.byte_done  = (prod_inc == total_q);
		sts.out_free   = !out_valid_q || out_ready;
	end

	// stream state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_cnt_q   <= '0;
			magic_q     <= '0;
			total_q     <= '0;
			prod_q      <= '0;
			flag_q      <= '0;
			flag_left_q <= '0;
			low_q       <= '0;
			wp_q        <= WP_INIT;
			src_q       <= '0;
			len_q       <= '0;
		end else begin
			if (cmd.hdr_step) begin
				if (hdr_cnt_q <= HDR_MAGIC_END)
					magic_q <= magic_next;
				else if (hdr_cnt_q <= HDR_LEN_END)
					total_q <= {total_q[23:0], byte_q};
				hdr_cnt_q <= hdr_cnt_q + 4'd1;
			end
			if (cmd.flag_load) begin
				flag_q      <= byte_q;
				flag_left_q <= FLAG_UNITS;
			end else if (cmd.unit_done) begin
				flag_q <= {1'b0, flag_q[7:1]};
				if (flag_left_q != '0)
					flag_left_q <= flag_left_q - 4'd1;
			end
			if (cmd.low_load)
				low_q <= byte_q;
			if (cmd.copy_start) begin
				src_q <= {byte_q[7:4], low_q};
				len_q <= LEN_W'(byte_q[3:0]) + LEN_W'(MIN_MATCH);
			end else if (cmd.emit_copy) begin
				src_q <= src_q + WIN_AW'(1);
				len_q <= len_q - LEN_W'(1);
			end
			if (ring_we) begin
				wp_q   <= wp_q + WIN_AW'(1);
				prod_q <= prod_inc;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in)
			byte_q <= in_byte;
	end

	// history ring, one port used per cycle
	always_ff @(posedge clk) begin
		if (ring_we)
			ring[wp_q] <= ring_wdata;
		if (cmd.rd_issue) begin
			rd_data_q <= ring[src_q];
			rd_ok_q   <= src_filled;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ring_we || cmd.emit_err) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_lit || cmd.emit_copy) begin
			out_byte_q <= ring_wdata;
			out_last_q <= cmd.emit_lit || sts.copy_last || sts.byte_done;
			out_done_q <= sts.byte_done;
			out_bad_q  <= 1'b0;
		end else if (cmd.emit_err) begin
			out_byte_q <= 8'h00;
			out_last_q <= 1'b1;
			out_done_q <= 1'b0;
			out_bad_q  <= 1'b1;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_byte    = out_byte_q;
	assign run_last    = out_last_q;
	assign stream_done = out_done_q;
	assign bad_magic   = out_bad_q;

endmodule

// File: rtl/core/lzss_stream_decoder.sv
// top level of the lzss stream decoder: byte stream in, decoded bytes out
// depends on lzss_pkg, lzss_ctrl and lzss_dp
//
//  channel | dir | tdata          | tlast    | tuser
//  s_*     | in  | [7:0] in_byte  | -        | -
//  m_*     | out | [7:0] out_byte | run_last | [0] stream_done, [1] bad_magic
//
// a byte is taken in ST_IDLE and decoded in ST_DECODE; a literal then passes ST_LIT, and a
// match alternates ST_RD and ST_WR for each copied byte (up to 18 bytes), set by the single
// ring port with its registered read
// one output register parts the sides: header, flag and match bytes are taken while a
// result waits; an emit waits for m_tready
// no clearing pass: a fill count of output bytes marks which ring entries are written,
// the rest read as zero; a new stream needs arst_n
module lzss_stream_decoder
	import lzss_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] in_byte
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_byte
	output logic       m_tlast,   // run_last
	output logic [1:0] m_tuser    // [0] stream_done, [1] bad_magic
);

	dp_cmd_t cmd;
	dp_sts_t sts;
	logic    done_bit;
	logic    bad_bit;

	// sequencer: stream phase and per-byte steps
	lzss_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// header and flag registers, history ring, output register
	lzss_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_byte     (s_tdata),
		.cmd         (cmd),
		.sts         (sts),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_byte    (m_tdata),
		.run_last    (m_tlast),
		.stream_done (done_bit),
		.bad_magic   (bad_bit)
	);

	assign m_tuser = {bad_bit, done_bit};

endmodule

// File: rtl/core/lzss_chk.sv
// port checker of the lzss stream decoder, bound to the top level
// depends on assert_macros.svh
`include "assert_macros.svh"

module lzss_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tlast,
	input logic [1:0] m_tuser
);

	logic        ended_q;
	logic [10:0] m_bus;

	assign m_bus = {m_tlast, m_tuser, m_tdata};

	// a transfer that finishes or abandons the stream ends all output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ended_q <= 1'b0;
		end else if (m_tvalid && m_tready && (m_tuser != 2'b00)) begin
			ended_q <= 1'b1;
		end
	end

	`LZSS_ASSERT(a_out_hold, clk, arst_n, m_tvalid && !m_tready |=> m_tvalid, "output dropped while stalled")
	`LZSS_ASSERT(a_out_stable, clk, arst_n, m_tvalid && !m_tready |=> $stable(m_bus), "output changed while stalled")
	`LZSS_ASSERT(a_err_form, clk, arst_n, m_tvalid && m_tuser[1] |-> m_tlast && (m_tdata == 8'h00) && !m_tuser[0], "malformed error result")
	`LZSS_ASSERT(a_done_last, clk, arst_n, m_tvalid && m_tuser[0] |-> m_tlast, "stream end not marked last")
	`LZSS_ASSERT(a_quiet_end, clk, arst_n, ended_q |-> !m_tvalid, "output after end of stream")

endmodule

bind lzss_stream_decoder lzss_chk u_chk (.*);
